[src/fcwp_pkg.sv]
`default_nettype none

package fcwp_pkg;

  localparam int ADDR_W = 20;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;
  localparam logic TGT_FLASH = 1'b0;
  localparam logic TGT_REG   = 1'b1;

  localparam logic [ADDR_W-1:0] REG_READY = 20'h00400;
  localparam logic [ADDR_W-1:0] REG_MODE  = 20'h00504;
  localparam logic [ADDR_W-1:0] REG_ERASE = 20'h00508;

  localparam logic [1:0] MODE_RO  = 2'd0;
  localparam logic [1:0] MODE_WEN = 2'd1;
  localparam logic [1:0] MODE_EEN = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic              op;
    logic              target;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
  } out_t;

endpackage

`default_nettype wire

[src/flash_controller_word_program_page_erase.sv]
`default_nettype none

// Channel  Ports                          Handshake
// input    start, busy, in_item           beat taken when start && !busy
// result   out_strobe, out_item           one-cycle strobe, always taken
//
// Register accesses other than erase writes, flagged flash accesses: answered in idle, busy low.
// Flash read and word program: through the single RAM port, via S_FRD or S_PRG.
// Erase write: accepted, then checked in S_EQ, S_EM, S_ECK; a good page adds PAGE_WORDS writes.
// After reset the array is swept to ones, word by word in S_INIT, with busy high.
// The result side has no stall; each result shows for one cycle after the item ends.

module flash_controller_word_program_page_erase #(
  parameter int FLASH_WORDS = 262144,
  parameter int PAGE_WORDS  = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire fcwp_pkg::in_t  in_item,
  output logic                busy,
  output logic                out_strobe,
  output fcwp_pkg::out_t      out_item
);

  localparam int IW = fcwp_pkg::IDX_W;
  localparam int DW = fcwp_pkg::DATA_W;
  localparam int AWD = fcwp_pkg::ADDR_W;
  localparam int AW = $clog2(FLASH_WORDS > 1 ? FLASH_WORDS : 2);
  localparam logic [IW:0]   FW_L      = (IW+1)'(FLASH_WORDS);
  localparam logic [IW-1:0] PW_L      = IW'(PAGE_WORDS);
  localparam logic [IW:0]   RECIP     = (IW+1)'((1 << IW) / PAGE_WORDS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(FLASH_WORDS - 1);
  localparam logic [AW-1:0] PAGE_SPAN = AW'(PAGE_WORDS - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_FRD, S_PRG, S_EQ, S_EM, S_ECK, S_ERASE
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [DW-1:0]        data_r, data_nxt;
  logic [IW-1:0]        q_r, q_nxt;
  logic [IW-1:0]        qp_r, qp_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  fcwp_pkg::out_t       out_item_r, out_item_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [DW-1:0]        ram_wdata;
  logic [DW-1:0]        ram_rdata;

  logic [IW-1:0]        idx;
  logic                 flash_bad;
  logic [IW-1:0]        first;
  logic [2*IW:0]        prod_q;
  logic [2*IW-1:0]      prod_p;
  logic [IW-1:0]        rem;
  logic [IW+1:0]        end_sum;
  logic                 page_ok;

  fcwp_ram #(
    .WIDTH(DW),
    .DEPTH(FLASH_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign idx       = in_item.address[AWD-1:2];
  assign flash_bad = (in_item.address[1:0] != 2'b00) || ({1'b0, idx} >= FW_L);

  assign first   = data_r[AWD-1:2];
  assign prod_q  = {{(IW+1){1'b0}}, first} * {{IW{1'b0}}, RECIP};
  assign prod_p  = {{IW{1'b0}}, q_r} * {{IW{1'b0}}, PW_L};
  assign rem     = first - qp_r;
  assign end_sum = {2'b00, first} + {2'b00, PW_L};
  assign page_ok = (data_r[DW-1:AWD] == '0) && (data_r[1:0] == 2'b00) &&
                   ((rem == '0) || (rem == PW_L)) && (end_sum <= {1'b0, FW_L});

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ptr_r;
    ram_wdata = '1;
    unique case (state_r)
      S_INIT, S_ERASE: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_addr = idx[AW-1:0];
      end
      S_PRG: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & data_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    last_nxt       = last_r;
    mode_nxt       = mode_r;
    data_nxt       = data_r;
    q_nxt          = q_r;
    qp_nxt         = qp_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;

    unique case (state_r)
      S_INIT: begin
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_item.target == fcwp_pkg::TGT_FLASH) begin
            if (flash_bad) begin
              out_strobe_nxt      = 1'b1;
              out_item_nxt.status = fcwp_pkg::ST_RANGE;
            end else if (in_item.op == fcwp_pkg::OP_READ) begin
              state_nxt = S_FRD;
            end else if (mode_r != fcwp_pkg::MODE_WEN) begin
              out_strobe_nxt      = 1'b1;
              out_item_nxt.status = fcwp_pkg::ST_DISABLED;
            end else begin
              ptr_nxt   = idx[AW-1:0];
              data_nxt  = in_item.data;
              state_nxt = S_PRG;
            end
          end else if (in_item.address[1:0] != 2'b00) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.status = fcwp_pkg::ST_RANGE;
          end else begin
            unique case (in_item.address)
              fcwp_pkg::REG_READY: begin
                out_strobe_nxt = 1'b1;
                if (in_item.op == fcwp_pkg::OP_READ) begin
                  out_item_nxt.read_data = DW'(1);
                end
              end
              fcwp_pkg::REG_MODE: begin
                out_strobe_nxt = 1'b1;
                if (in_item.op == fcwp_pkg::OP_WRITE) begin
                  mode_nxt = in_item.data[1:0];
                end else begin
                  out_item_nxt.read_data = {{(DW-2){1'b0}}, mode_r};
                end
              end
              fcwp_pkg::REG_ERASE: begin
                if (in_item.op == fcwp_pkg::OP_WRITE) begin
                  data_nxt  = in_item.data;
                  state_nxt = S_EQ;
                end else begin
                  out_strobe_nxt = 1'b1;
                end
              end
              default: begin
                out_strobe_nxt      = 1'b1;
                out_item_nxt.status = fcwp_pkg::ST_UNKNOWN;
              end
            endcase
          end
        end
      end
      S_FRD: begin
        out_strobe_nxt         = 1'b1;
        out_item_nxt.read_data = ram_rdata;
        state_nxt              = S_IDLE;
      end
      S_PRG: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_EQ: begin
        q_nxt     = prod_q[2*IW-1:IW];
        state_nxt = S_EM;
      end
      S_EM: begin
        qp_nxt    = prod_p[IW-1:0];
        state_nxt = S_ECK;
      end
      S_ECK: begin
        if (!page_ok) begin
          out_strobe_nxt      = 1'b1;
          out_item_nxt.status = fcwp_pkg::ST_RANGE;
          state_nxt           = S_IDLE;
        end else if (mode_r != fcwp_pkg::MODE_EEN) begin
          out_strobe_nxt      = 1'b1;
          out_item_nxt.status = fcwp_pkg::ST_DISABLED;
          state_nxt           = S_IDLE;
        end else begin
          ptr_nxt   = first[AW-1:0];
          last_nxt  = first[AW-1:0] + PAGE_SPAN;
          state_nxt = S_ERASE;
        end
      end
      S_ERASE: begin
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == last_r) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    data_r     <= data_nxt;
    q_r        <= q_nxt;
    qp_r       <= qp_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r      <= S_INIT;
      ptr_r        <= '0;
      mode_r       <= fcwp_pkg::MODE_RO;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      mode_r       <= mode_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

[src/fcwp_ram.sv]
`default_nettype none

module fcwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  wire logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int FLASH_WORDS = 262144;
  localparam int PAGE_WORDS  = 1024;
  localparam int PAGE_BYTES  = PAGE_WORDS * 4;
  localparam int RANDOM_BEATS = 550;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  fcwp_pkg::in_t  in_item;
  logic busy;
  logic out_strobe;
  fcwp_pkg::out_t out_item;

  logic [1:0]  mode_shadow;
  logic [31:0] flash_image [int unsigned];
  fcwp_pkg::out_t pending_results [$];

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_programmed;
  int unsigned n_erased;
  int unsigned n_fail;
  int unsigned burst_left;
  int unsigned cycle_cnt;

  flash_controller_word_program_page_erase #(
    .FLASH_WORDS(FLASH_WORDS),
    .PAGE_WORDS (PAGE_WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("flash_controller_word_program_page_erase regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] stored_word(input int unsigned idx);
    return flash_image.exists(idx) ? flash_image[idx] : 32'hFFFF_FFFF;
  endfunction

  function automatic fcwp_pkg::out_t predict_access(input fcwp_pkg::in_t beat);
    fcwp_pkg::out_t res;
    logic [1:0]  st;
    logic [31:0] rd;
    int unsigned idx;
    int unsigned first;
    int unsigned i;
    rd = '0;
    st = fcwp_pkg::ST_OK;
    if (beat.target == fcwp_pkg::TGT_REG) begin
      if (beat.address[1:0] != 2'b00) begin
        st = fcwp_pkg::ST_RANGE;
      end else if (beat.address == fcwp_pkg::REG_READY) begin
        rd = 32'd1;
      end else if (beat.address == fcwp_pkg::REG_MODE) begin
        if (beat.op == fcwp_pkg::OP_WRITE) mode_shadow = beat.data[1:0];
        else rd = {30'b0, mode_shadow};
      end else if (beat.address == fcwp_pkg::REG_ERASE) begin
        if (beat.op == fcwp_pkg::OP_WRITE) begin
          first = beat.data >> 2;
          if ((beat.data % PAGE_BYTES) != 0 || first >= FLASH_WORDS ||
              FLASH_WORDS - first < PAGE_WORDS) begin
            st = fcwp_pkg::ST_RANGE;
          end else if (mode_shadow != fcwp_pkg::MODE_EEN) begin
            st = fcwp_pkg::ST_DISABLED;
          end else begin
            for (i = 0; i < PAGE_WORDS; i++) flash_image.delete(first + i);
            n_erased++;
          end
        end
      end else begin
        st = fcwp_pkg::ST_UNKNOWN;
      end
    end else begin
      idx = beat.address >> 2;
      if (beat.address[1:0] != 2'b00 || idx >= FLASH_WORDS) begin
        st = fcwp_pkg::ST_RANGE;
      end else if (beat.op == fcwp_pkg::OP_READ) begin
        rd = stored_word(idx);
      end else if (mode_shadow != fcwp_pkg::MODE_WEN) begin
        st = fcwp_pkg::ST_DISABLED;
      end else begin
        flash_image[idx] = stored_word(idx) & beat.data;
        n_programmed++;
      end
    end
    if (st != fcwp_pkg::ST_OK || beat.op == fcwp_pkg::OP_WRITE) rd = '0;
    res.read_data = rd;
    res.status    = st;
    return res;
  endfunction

  task automatic bus_access(input logic op, input logic tgt,
                            input logic [fcwp_pkg::ADDR_W-1:0] addr,
                            input logic [fcwp_pkg::DATA_W-1:0] data);
    fcwp_pkg::in_t beat;
    beat.op      = op;
    beat.target  = tgt;
    beat.address = addr;
    beat.data    = data;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_access(beat));
    n_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic set_mode(input logic [1:0] m);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE, {30'b0, m});
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    fcwp_pkg::out_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: read_data %h status %0d",
               out_item.read_data, out_item.status);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_item.read_data !== want.read_data) begin
          $error("read_data expected %h actual %h", want.read_data, out_item.read_data);
          n_fail++;
        end
        if (out_item.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_item.status);
          n_fail++;
        end
      end
    end
  end

  function automatic logic [7:0] hot_page();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd3;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [fcwp_pkg::ADDR_W-1:0] hot_word_addr();
    logic [9:0] w;
    w = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 15));
    return {hot_page(), w, 2'b00};
  endfunction

  task automatic test_register_space();
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_READY, 32'hFFFF_FFFF);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_READY, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE,  32'h0000_0000);
    set_mode(2'd3);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE,  32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'h00010, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE + 20'd2,
               32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, 20'h00000, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, 20'hFFFFC, 32'hFFFF_FFFF);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE, 32'hFFFF_FFFC);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_REG, fcwp_pkg::REG_MODE, 32'h0000_0000);
  endtask

  task automatic test_flash_words();
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'h00000, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'h00000, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'h00001, 32'h0000_0000);
    set_mode(fcwp_pkg::MODE_WEN);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'h00000, 32'hA5A5_F0F0);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'h00000, 32'h0FF0_FFFF);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'h00000, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'hFFFFC, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'hFFFFC, 32'h0000_0000);
  endtask

  task automatic test_page_erase();
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h0000_0000);
    set_mode(fcwp_pkg::MODE_EEN);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h0000_0100);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h0010_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'hFFFF_F000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, 20'h00004, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'h00000, 32'h0000_0000);
    bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE, 32'h000F_F000);
    bus_access(fcwp_pkg::OP_READ,  fcwp_pkg::TGT_FLASH, 20'hFFFFC, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    int unsigned pick;
    logic [fcwp_pkg::ADDR_W-1:0] addr;
    logic [31:0] raw;
    base = n_sent;
    while (n_sent - base < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        set_mode(fcwp_pkg::MODE_WEN);
        repeat ($urandom_range(1, 6))
          bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_FLASH, hot_word_addr(),
                     $urandom() | $urandom());
        repeat ($urandom_range(1, 4))
          bus_access(fcwp_pkg::OP_READ, fcwp_pkg::TGT_FLASH, hot_word_addr(), $urandom());
      end else if (pick < 52) begin
        set_mode(fcwp_pkg::MODE_EEN);
        bus_access(fcwp_pkg::OP_WRITE, fcwp_pkg::TGT_REG, fcwp_pkg::REG_ERASE,
                   {12'b0, hot_page(), 12'b0});
        repeat ($urandom_range(1, 3))
          bus_access(fcwp_pkg::OP_READ, fcwp_pkg::TGT_FLASH, hot_word_addr(), $urandom());
      end else if (pick < 75) begin
        raw = $urandom();
        addr = ($urandom_range(0, 3) == 0) ? {raw[19:2], 2'b00} : hot_word_addr();
        bus_access(fcwp_pkg::OP_READ, fcwp_pkg::TGT_FLASH, addr, $urandom());
      end else if (pick < 88) begin
        bus_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 20'($urandom()),
                   $urandom());
      end else begin
        case ($urandom_range(0, 3))
          0: addr = fcwp_pkg::REG_READY;
          1: addr = fcwp_pkg::REG_MODE;
          2: addr = fcwp_pkg::REG_ERASE;
          default: addr = 20'($urandom());
        endcase
        if ($urandom_range(0, 3) == 0) addr[1:0] = 2'($urandom_range(1, 3));
        bus_access(1'($urandom_range(0, 1)), fcwp_pkg::TGT_REG, addr, $urandom());
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    mode_shadow  = fcwp_pkg::MODE_RO;
    n_sent       = 0;
    n_checked    = 0;
    n_programmed = 0;
    n_erased     = 0;
    n_fail       = 0;
    burst_left   = 0;
    cycle_cnt    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_space();
    drain_results();
    test_flash_words();
    drain_results();
    test_page_erase();
    drain_results();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    drain_results();
    repeat (1100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_fail++;
    end

    $display("covered %0d bus beats, %0d results checked", n_sent, n_checked);
    $display("word programs %0d, page erases %0d, mismatches %0d",
             n_programmed, n_erased, n_fail);
    if (n_fail == 0) begin
      $display("flash_controller_word_program_page_erase regression: pass");
    end else begin
      $display("flash_controller_word_program_page_erase regression: fail");
    end
    $finish;
  end

endmodule
